/* rtl/ledsfs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ledsfs_pkg: shared types and constants of the LED driver frame sequencer
// Item layouts, operation and register codes, frame parts, and the
// command and status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ledsfs_pkg;

    localparam int MAX_DIGITS  = 16;
    localparam int DIGIT_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W       = 5;    // byte counter and digit count width

    // operation codes of an input item
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_REFRESH = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_INTENSITY = 2'd0;
    localparam logic [1:0] REG_REVERSE   = 2'd1;
    localparam logic [1:0] REG_DIGITS    = 2'd2;

    localparam int CFG_DATA_W = 5;

    // frame parts
    localparam logic [2:0] PART_IDLE  = 3'd0;
    localparam logic [2:0] PART_START = 3'd1;
    localparam logic [2:0] PART_BITS  = 3'd2;
    localparam logic [2:0] PART_ACK   = 3'd3;
    localparam logic [2:0] PART_STOP  = 3'd4;

    // bytes of the frame
    localparam logic [7:0] CMD_DATA = 8'h40;
    localparam logic [7:0] CMD_ADDR = 8'hC0;
    localparam logic [7:0] CMD_CTRL = 8'h80;
    localparam logic [7:0] CTRL_ON  = 8'h08;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] digit_index;
        logic [7:0] segment_bits;
        logic       data_line_sense;
    } t_in_item;

    typedef struct packed {
        logic clock_released;
        logic data_released;
        logic busy_res;
        logic frame_done;
    } t_out_item;

    typedef struct packed {
        logic             write;
        logic             clear;
        logic             load;
        logic [CNT_W-1:0] load_index;
        logic             shift;
        logic             clk_low;
        logic             clk_high;
        logic             data_low;
        logic             data_high;
        logic             data_bit;
    } t_dp_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] used_count;
    } t_dp_stat;

    typedef struct packed {
        logic clock;
        logic data;
    } t_line;

endpackage : ledsfs_pkg
`default_nettype wire

/* rtl/led_driver_serial_frame_sequencer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// led_driver_serial_frame_sequencer: two-wire LED driver write-frame sequencer
// Digit buffer plus a tick-driven frame generator for open-drain clock and
// data lines; one result item per input item.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle and returns exactly one result
// for each, in the cycle after acceptance, through an output register. The
// input stalls only while a result waits in that register and the consumer
// stalls; otherwise a new item enters every cycle. Write items store a
// segment byte, clear items zero all sixteen digits at once (no sweep), a
// refresh item opens a frame and each tick item advances it by one
// bit-delay interval. A frame is three parts, each opened by a one-tick
// start and closed by a three-tick stop; every byte takes 24 ticks of bits
// (LSB first) and 4 ticks of acknowledge, so a frame with N digits lasts
// 28*(N+3) + 3*(1+3) ticks. The result carries the line levels held after
// the item, the busy flag and a done pulse on the tick that ends the frame.
// Configuration writes (intensity, reverse order, digits used) are taken
// on any cycle the write enable is high and are read live by the frame.
// ----------------------------------------------------------------------------
module led_driver_serial_frame_sequencer (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // input item channel
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire  ledsfs_pkg::t_in_item        i_in_item,
    // result item channel
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output ledsfs_pkg::t_out_item             o_out_item,
    // configuration write port
    input  wire                               i_cfg_we,
    input  wire  [1:0]                        i_cfg_index,
    input  wire  [ledsfs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ledsfs_pkg::*;

    logic      accept;
    t_dp_cmd   cmd;
    t_dp_stat  stat;
    t_line     line_next;
    logic      busy_next;
    logic      done;

    logic      r_out_valid;
    t_out_item r_out_item;

    // hold the input while a result waits and the consumer stalls
    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    ledsfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_opcode    (i_in_item.opcode),
        .i_sense     (i_in_item.data_line_sense),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy_next (busy_next),
        .o_done      (done)
    );

    ledsfs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_digit_index  (i_in_item.digit_index),
        .i_segment_bits (i_in_item.segment_bits),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_line_next    (line_next)
    );

    // capture the post-item levels and flags; drop the valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item.clock_released <= line_next.clock;
            r_out_item.data_released  <= line_next.data;
            r_out_item.busy_res       <= busy_next;
            r_out_item.frame_done     <= done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !accept)
        else $error("item accepted over a waiting result");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.frame_done) |-> !r_out_item.busy_res)
        else $error("frame done reported while still busy");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted item produced no result");
`endif

endmodule : led_driver_serial_frame_sequencer
`default_nettype wire

/* rtl/ledsfs_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ledsfs_dp: datapath of the LED driver frame sequencer
// Digit buffer, configuration registers, byte selection, shift register
// and the two open-drain line levels.
// ----------------------------------------------------------------------------
module ledsfs_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [1:0]                   i_cfg_index,
    input  wire  [ledsfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire  [3:0]                   i_digit_index,
    input  wire  [7:0]                   i_segment_bits,
    input  wire  ledsfs_pkg::t_dp_cmd    i_cmd,
    output ledsfs_pkg::t_dp_stat         o_stat,
    output ledsfs_pkg::t_line            o_line_next
);
    import ledsfs_pkg::*;

    logic [2:0]       r_intensity;
    logic             r_reverse;
    logic [CNT_W-1:0] r_digits_used;
    logic [7:0]       r_digits [MAX_DIGITS];
    logic [7:0]       r_shift;
    logic             r_clock;
    logic             r_data;

    logic             n_clock;
    logic             n_data;
    logic [CNT_W-1:0] used;
    logic [CNT_W:0]   c_ext;
    logic [CNT_W:0]   n_ext;
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] idx;
    logic [7:0]       sel_byte;

    // saturate the digit count to the buffer size
    always_comb begin
        if (r_digits_used > CNT_W'(MAX_DIGITS)) begin
            used = CNT_W'(MAX_DIGITS);
        end else begin
            used = r_digits_used;
        end
    end

    assign o_stat.used_count = used;

    always_comb begin
        c_ext = {1'b0, i_cmd.load_index};
        n_ext = {1'b0, used};
        k     = i_cmd.load_index - CNT_W'(2);
        idx   = r_reverse ? (used - CNT_W'(1) - k) : k;
        if (i_cmd.load_index == CNT_W'(0)) begin
            sel_byte = CMD_DATA;
        end else if (i_cmd.load_index == CNT_W'(1)) begin
            sel_byte = CMD_ADDR;
        end else if (c_ext >= n_ext + (CNT_W+1)'(2)) begin
            sel_byte = CMD_CTRL | CTRL_ON | {5'd0, r_intensity};
        end else if (idx >= CNT_W'(MAX_DIGITS)) begin
            sel_byte = 8'h00;
        end else begin
            sel_byte = r_digits[idx[DIGIT_IDX_W-1:0]];
        end
    end

    always_comb begin
        n_clock = r_clock;
        n_data  = r_data;
        if (i_cmd.clk_low) begin
            n_clock = 1'b0;
        end else if (i_cmd.clk_high) begin
            n_clock = 1'b1;
        end
        if (i_cmd.data_low) begin
            n_data = 1'b0;
        end else if (i_cmd.data_high) begin
            n_data = 1'b1;
        end else if (i_cmd.data_bit) begin
            n_data = r_shift[0];
        end
    end

    assign o_line_next.clock = n_clock;
    assign o_line_next.data  = n_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intensity   <= 3'd7;
            r_reverse     <= 1'b0;
            r_digits_used <= CNT_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_INTENSITY: r_intensity   <= i_cfg_data[2:0];
                REG_REVERSE:   r_reverse     <= i_cfg_data[0];
                REG_DIGITS:    r_digits_used <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_digits[i] <= 8'h00;
            end
        end else if (i_cmd.write &&
                     ({1'b0, i_digit_index} < 5'(MAX_DIGITS))) begin
            r_digits[i_digit_index[DIGIT_IDX_W-1:0]] <= i_segment_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 8'h00;
            r_clock <= 1'b0;
            r_data  <= 1'b0;
        end else begin
            r_clock <= n_clock;
            r_data  <= n_data;
            if (i_cmd.load) begin
                r_shift <= sel_byte;
            end else if (i_cmd.shift) begin
                r_shift <= {1'b0, r_shift[7:1]};
            end
        end
    end

endmodule : ledsfs_dp
`default_nettype wire

/* rtl/ledsfs_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ledsfs_ctrl: frame controller of the LED driver frame sequencer
// Steps the frame parts, tick phases, bit and byte counters and issues
// datapath commands for each accepted item.
// ----------------------------------------------------------------------------
module ledsfs_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  wire  [1:0]            i_opcode,
    input  wire                   i_sense,
    input  wire  ledsfs_pkg::t_dp_stat i_stat,
    output ledsfs_pkg::t_dp_cmd   o_cmd,
    output logic                  o_busy_next,
    output logic                  o_done
);
    import ledsfs_pkg::*;

    logic [2:0]       r_part;
    logic [1:0]       r_phase;
    logic [2:0]       r_bit;
    logic [CNT_W-1:0] r_byte;

    logic [2:0]       n_part;
    logic [1:0]       n_phase;
    logic [2:0]       n_bit;
    logic [CNT_W-1:0] n_byte;
    logic [CNT_W:0]   byte_ext;
    logic [CNT_W:0]   used_ext;
    t_dp_cmd          cmd;
    logic             done;

    assign byte_ext = {1'b0, r_byte};
    assign used_ext = {1'b0, i_stat.used_count};

    always_comb begin
        n_part  = r_part;
        n_phase = r_phase;
        n_bit   = r_bit;
        n_byte  = r_byte;
        cmd     = '0;
        done    = 1'b0;

        if (i_accept) begin
            case (i_opcode)
                OP_WRITE: cmd.write = 1'b1;
                OP_CLEAR: cmd.clear = 1'b1;
                OP_REFRESH: begin
                    if (r_part == PART_IDLE) begin
                        n_part  = PART_START;
                        n_byte  = '0;
                        n_bit   = '0;
                        n_phase = '0;
                    end
                end
                OP_TICK: begin
                    case (r_part)
                        PART_IDLE: begin
                        end
                        PART_START: begin
                            cmd.data_low   = 1'b1;
                            cmd.load       = 1'b1;
                            cmd.load_index = r_byte;
                            n_part  = PART_BITS;
                            n_bit   = '0;
                            n_phase = '0;
                        end
                        PART_BITS: begin
                            case (r_phase)
                                2'd0: begin
                                    cmd.clk_low = 1'b1;
                                    n_phase     = 2'd1;
                                end
                                2'd1: begin
                                    cmd.data_bit = 1'b1;
                                    n_phase      = 2'd2;
                                end
                                default: begin
                                    cmd.clk_high = 1'b1;
                                    cmd.shift    = 1'b1;
                                    n_phase      = 2'd0;
                                    if (r_bit == 3'd7) begin
                                        n_bit  = '0;
                                        n_part = PART_ACK;
                                    end else begin
                                        n_bit = r_bit + 3'd1;
                                    end
                                end
                            endcase
                        end
                        PART_ACK: begin
                            case (r_phase)
                                2'd0: begin
                                    cmd.clk_low   = 1'b1;
                                    cmd.data_high = 1'b1;
                                    n_phase       = 2'd1;
                                end
                                2'd1: begin
                                    cmd.clk_high = 1'b1;
                                    n_phase      = 2'd2;
                                end
                                2'd2: begin
                                    // receiver pulls data low: drive it low too
                                    cmd.data_low = !i_sense;
                                    n_phase      = 2'd3;
                                end
                                default: begin
                                    cmd.clk_high = 1'b1;
                                    n_phase      = 2'd0;
                                    if (r_byte == '0 ||
                                        byte_ext >= used_ext + (CNT_W+1)'(1)) begin
                                        n_part = PART_STOP;
                                    end else begin
                                        n_byte         = r_byte + CNT_W'(1);
                                        cmd.load       = 1'b1;
                                        cmd.load_index = r_byte + CNT_W'(1);
                                        n_part         = PART_BITS;
                                        n_bit          = '0;
                                    end
                                end
                            endcase
                        end
                        PART_STOP: begin
                            case (r_phase)
                                2'd0: begin
                                    cmd.data_low = 1'b1;
                                    n_phase      = 2'd1;
                                end
                                2'd1: begin
                                    cmd.clk_high = 1'b1;
                                    n_phase      = 2'd2;
                                end
                                default: begin
                                    cmd.data_high = 1'b1;
                                    n_phase       = 2'd0;
                                    if (byte_ext >= used_ext + (CNT_W+1)'(2)) begin
                                        n_part = PART_IDLE;
                                        n_byte = '0;
                                        done   = 1'b1;
                                    end else begin
                                        n_byte = r_byte + CNT_W'(1);
                                        n_part = PART_START;
                                    end
                                end
                            endcase
                        end
                        default: n_part = PART_IDLE;
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cmd       = cmd;
    assign o_busy_next = (n_part != PART_IDLE);
    assign o_done      = done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part  <= PART_IDLE;
            r_phase <= '0;
            r_bit   <= '0;
            r_byte  <= '0;
        end else begin
            r_part  <= n_part;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_byte  <= n_byte;
        end
    end

`ifndef ASSERT_OFF
    a_bit_only_in_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_part != PART_BITS) |-> (r_bit == 3'd0))
        else $error("bit counter nonzero outside the bit part");

    a_phase3_only_in_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_part != PART_ACK) |-> (r_phase != 2'd3))
        else $error("fourth tick phase outside the acknowledge part");

    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_part == PART_IDLE) |-> (r_byte == '0))
        else $error("byte counter nonzero while idle");

    a_done_from_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> (r_part == PART_STOP && r_phase == 2'd2 && !o_busy_next))
        else $error("frame done outside the final stop");
`endif

endmodule : ledsfs_ctrl
`default_nettype wire

/* tb/ledsfs_line_monitor.sv */
// ----------------------------------------------------------------------------
// ledsfs_line_monitor: line-level scoreboard of the LED frame sequencer
// Watches the item, result and register channels, keeps its own copy of the
// digit buffer, frame position and line levels, and compares every result
// with the levels that the frame should hold after the matching item.
// ----------------------------------------------------------------------------
module ledsfs_line_monitor (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    input  wire                               i_in_stall,
    input  ledsfs_pkg::t_in_item              i_in_item,
    input  wire                               i_out_valid,
    input  wire                               i_out_stall,
    input  ledsfs_pkg::t_out_item             i_out_item,
    input  wire                               i_cfg_we,
    input  wire  [1:0]                        i_cfg_index,
    input  wire  [ledsfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import ledsfs_pkg::*;

    // register copies
    logic [2:0]       lvl_reg;
    logic             rev_reg;
    logic [CNT_W-1:0] used_reg;

    // frame state copies
    logic [7:0]       digit_mem [MAX_DIGITS];
    logic [2:0]       part;
    logic [CNT_W-1:0] byte_num;
    logic [2:0]       bit_num;
    logic [1:0]       tick_ph;
    logic [7:0]       shreg;
    logic             clk_lvl;
    logic             dat_lvl;

    t_out_item        expected_lines_q [$];
    t_out_item        want;
    t_out_item        line_now;
    logic             done_now;
    int               n_sent;
    int               err_count = 0;
    int               result_num = 0;

    task automatic flag_error(input string msg);
        $display("ERROR @%0t result %0d: %s", $realtime, result_num, msg);
        err_count++;
    endtask

    // digits_used saturates at the buffer depth
    function automatic int digits_sent();
        return (used_reg > MAX_DIGITS) ? MAX_DIGITS : int'(used_reg);
    endfunction

    // open the next byte of the frame; digits are read here, not earlier
    task automatic load_byte();
        int n;
        int k;
        int idx;
        n       = digits_sent();
        part    = PART_BITS;
        bit_num = '0;
        tick_ph = '0;
        if (byte_num == 0) begin
            shreg = CMD_DATA;
        end else if (byte_num == 1) begin
            shreg = CMD_ADDR;
        end else if (int'(byte_num) >= n + 2) begin
            shreg = CMD_CTRL | CTRL_ON | {5'b0, lvl_reg};
        end else begin
            k     = int'(byte_num) - 2;
            idx   = rev_reg ? (n - 1 - k) : k;
            shreg = (idx >= 0 && idx < MAX_DIGITS) ? digit_mem[idx] : 8'h00;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lvl_reg  = 3'd7;
            rev_reg  = 1'b0;
            used_reg = 5'd16;
            foreach (digit_mem[i]) digit_mem[i] = 8'h00;
            part     = PART_IDLE;
            byte_num = '0;
            bit_num  = '0;
            tick_ph  = '0;
            shreg    = '0;
            clk_lvl  = 1'b0;
            dat_lvl  = 1'b0;
            expected_lines_q.delete();
        end else begin
            // results first: an item taken at this edge cannot answer yet
            if (i_out_valid && !i_out_stall) begin
                result_num++;
                if (expected_lines_q.size() == 0) begin
                    flag_error("result with no item waiting");
                end else begin
                    want = expected_lines_q.pop_front();
                    if (i_out_item.clock_released !== want.clock_released)
                        flag_error($sformatf("clock_released got %b want %b",
                                             i_out_item.clock_released,
                                             want.clock_released));
                    if (i_out_item.data_released !== want.data_released)
                        flag_error($sformatf("data_released got %b want %b",
                                             i_out_item.data_released,
                                             want.data_released));
                    if (i_out_item.busy_res !== want.busy_res)
                        flag_error($sformatf("busy_res got %b want %b",
                                             i_out_item.busy_res, want.busy_res));
                    if (i_out_item.frame_done !== want.frame_done)
                        flag_error($sformatf("frame_done got %b want %b",
                                             i_out_item.frame_done, want.frame_done));
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_INTENSITY: lvl_reg  = i_cfg_data[2:0];
                    REG_REVERSE:   rev_reg  = i_cfg_data[0];
                    REG_DIGITS:    used_reg = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end

            if (i_in_valid && !i_in_stall) begin
                done_now = 1'b0;
                n_sent   = digits_sent();
                case (i_in_item.opcode)
                    OP_WRITE: begin
                        if (i_in_item.digit_index < MAX_DIGITS)
                            digit_mem[i_in_item.digit_index] = i_in_item.segment_bits;
                    end
                    OP_REFRESH: begin
                        if (part == PART_IDLE) begin
                            part     = PART_START;
                            byte_num = '0;
                            bit_num  = '0;
                            tick_ph  = '0;
                        end
                    end
                    OP_TICK: begin
                        case (part)
                            PART_IDLE: ;
                            PART_START: begin
                                dat_lvl = 1'b0;
                                load_byte();
                            end
                            PART_BITS: begin
                                if (tick_ph == 0) begin
                                    clk_lvl = 1'b0;
                                    tick_ph = 2'd1;
                                end else if (tick_ph == 1) begin
                                    dat_lvl = shreg[0];
                                    tick_ph = 2'd2;
                                end else begin
                                    clk_lvl = 1'b1;
                                    shreg   = shreg >> 1;
                                    tick_ph = 2'd0;
                                    if (bit_num >= 3'd7) begin
                                        bit_num = '0;
                                        part    = PART_ACK;
                                    end else begin
                                        bit_num = bit_num + 3'd1;
                                    end
                                end
                            end
                            PART_ACK: begin
                                if (tick_ph == 0) begin
                                    clk_lvl = 1'b0;
                                    dat_lvl = 1'b1;
                                    tick_ph = 2'd1;
                                end else if (tick_ph == 1) begin
                                    clk_lvl = 1'b1;
                                    tick_ph = 2'd2;
                                end else if (tick_ph == 2) begin
                                    if (!i_in_item.data_line_sense) dat_lvl = 1'b0;
                                    tick_ph = 2'd3;
                                end else begin
                                    clk_lvl = 1'b1;
                                    tick_ph = 2'd0;
                                    if (byte_num == 0 || int'(byte_num) >= n_sent + 1) begin
                                        part = PART_STOP;
                                    end else begin
                                        byte_num = byte_num + 1'b1;
                                        load_byte();
                                    end
                                end
                            end
                            PART_STOP: begin
                                if (tick_ph == 0) begin
                                    dat_lvl = 1'b0;
                                    tick_ph = 2'd1;
                                end else if (tick_ph == 1) begin
                                    clk_lvl = 1'b1;
                                    tick_ph = 2'd2;
                                end else begin
                                    dat_lvl = 1'b1;
                                    tick_ph = 2'd0;
                                    if (int'(byte_num) >= n_sent + 2) begin
                                        part     = PART_IDLE;
                                        byte_num = '0;
                                        done_now = 1'b1;
                                    end else begin
                                        byte_num = byte_num + 1'b1;
                                        part     = PART_START;
                                    end
                                end
                            end
                            default: part = PART_IDLE;
                        endcase
                    end
                    default: begin
                        foreach (digit_mem[i]) digit_mem[i] = 8'h00;
                    end
                endcase
                line_now.clock_released = clk_lvl;
                line_now.data_released  = dat_lvl;
                line_now.busy_res       = (part != PART_IDLE);
                line_now.frame_done     = done_now;
                expected_lines_q.push_back(line_now);
            end
        end
        o_pending    <= expected_lines_q.size();
        o_fail_count <= err_count;
    end

endmodule : ledsfs_line_monitor

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the LED driver frame sequencer
// Drives digit writes, clears, refreshes and frame ticks through the item
// channel in bursts, stalls the result channel on a pattern of its own,
// reprograms the registers between phases, and lets the line monitor
// predict and compare every result.
// ----------------------------------------------------------------------------
module testbench;
    import ledsfs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 1050;
    localparam int RESET_CYCLES = 7;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} t_stall_mode;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_item   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [1:0]            cfg_index = REG_INTENSITY;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    wire                   in_stall;
    wire                   out_valid;
    t_out_item             out_item;

    int                    fail_count;
    int                    pending;
    int                    cycle_count = 0;
    int                    items_sent  = 0;
    int                    burst_left  = 0;
    int                    frame_left  = 0;   // rough count of ticks a frame still needs
    int                    cur_digits  = 16;
    t_stall_mode           stall_mode  = STALL_NONE;
    int                    stall_span  = 0;

    // 4-unit clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    led_driver_serial_frame_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ledsfs_line_monitor u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Hard stop: no correct run comes close to this many cycles.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result-side stall: switch pattern after each random-length span, including
    // stretches with no stall at all and long stall runs.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_mode <= t_stall_mode'($urandom_range(0, 3));
                stall_span <= $urandom_range(20, 80);
            end else begin
                stall_span <= stall_span - 1;
            end
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
                default:     out_stall <= ((stall_span % 8) < 5);
            endcase
        end
    end

    // Send one item. Between bursts drop valid for a random gap; inside a
    // burst keep valid high and just swap the payload. Hold the payload
    // until the block takes it.
    task automatic send_item(input logic [1:0] op, input logic [3:0] idx,
                             input logic [7:0] seg, input logic sense);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid             <= 1'b1;
        in_item.opcode          <= op;
        in_item.digit_index     <= idx;
        in_item.segment_bits    <= seg;
        in_item.data_line_sense <= sense;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    // Random items shaped around frames: when no frame should be running,
    // mostly load digits and start one, with stray ticks and clears; during a
    // frame mostly tick, with writes, clears and stray refreshes mixed in.
    task automatic send_random(input int count);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (frame_left == 0) begin
                if (r < 45) begin
                    send_item(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 255),
                              $urandom_range(0, 1));
                end else if (r < 55) begin
                    send_item(OP_TICK, $urandom_range(0, 15), $urandom_range(0, 255),
                              $urandom_range(0, 1));
                end else if (r < 60) begin
                    send_item(OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 255),
                              $urandom_range(0, 1));
                end else begin
                    send_item(OP_REFRESH, $urandom_range(0, 15), $urandom_range(0, 255),
                              $urandom_range(0, 1));
                    frame_left = 12 + 28 * (((cur_digits > MAX_DIGITS) ? MAX_DIGITS
                                                                       : cur_digits) + 3);
                end
            end else begin
                if (r < 90) begin
                    send_item(OP_TICK, $urandom_range(0, 15), $urandom_range(0, 255),
                              $urandom_range(0, 1));
                    frame_left--;
                end else if (r < 95) begin
                    send_item(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 255),
                              $urandom_range(0, 1));
                end else if (r < 97) begin
                    send_item(OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 255),
                              $urandom_range(0, 1));
                end else begin
                    // refresh during a frame: must be ignored
                    send_item(OP_REFRESH, $urandom_range(0, 15), $urandom_range(0, 255),
                              $urandom_range(0, 1));
                end
            end
        end
    endtask

    // Drop valid and wait until every expected result is back, then let the
    // output register settle.
    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write all three registers on back-to-back cycles, then drop the enable.
    task automatic set_config(input logic [2:0] lvl, input logic rev,
                              input logic [CNT_W-1:0] cnt);
        cfg_we    <= 1'b1;
        cfg_index <= REG_INTENSITY;
        cfg_data  <= {{(CFG_DATA_W-3){1'b0}}, lvl};
        @(posedge clk);
        cfg_index <= REG_REVERSE;
        cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, rev};
        @(posedge clk);
        cfg_index <= REG_DIGITS;
        cfg_data  <= cnt;
        @(posedge clk);
        cfg_we     <= 1'b0;
        cur_digits = cnt;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, reset register values.
        // Ticks with no frame running: lines must hold their reset levels.
        send_item(OP_TICK,    4'd0,  8'h00, 1'b0);
        send_item(OP_TICK,    4'd15, 8'hFF, 1'b1);
        // Field extremes on writes, then a clear wipes them.
        send_item(OP_WRITE,   4'd0,  8'hFF, 1'b0);
        send_item(OP_WRITE,   4'd15, 8'h00, 1'b1);
        send_item(OP_WRITE,   4'd15, 8'hA5, 1'b0);
        send_item(OP_WRITE,   4'd1,  8'h01, 1'b1);
        send_item(OP_WRITE,   4'd7,  8'h80, 1'b0);
        send_item(OP_CLEAR,   4'd0,  8'h00, 1'b0);
        send_item(OP_WRITE,   4'd0,  8'h3F, 1'b1);
        send_item(OP_WRITE,   4'd2,  8'h5B, 1'b0);
        // Open a frame and step into the first byte.
        send_item(OP_REFRESH, 4'd0,  8'h00, 1'b0);
        repeat (4) send_item(OP_TICK, 4'd0, 8'h00, 1'b1);
        // Refresh while busy: ignored.
        send_item(OP_REFRESH, 4'd3,  8'h11, 1'b1);
        repeat (3) send_item(OP_TICK, 4'd0, 8'h00, 1'b0);
        // Write and clear while busy: buffer changes at once.
        send_item(OP_WRITE,   4'd3,  8'hFF, 1'b1);
        send_item(OP_CLEAR,   4'd9,  8'h42, 1'b0);
        repeat (2) send_item(OP_TICK, 4'd0, 8'h00, 1'b1);
        drain();

        // Registers changed mid-frame: zero digits shortens the open frame.
        frame_left = 80;
        set_config(3'd0, 1'b1, 5'd0);
        send_random(120);
        drain();

        // Single digit, full brightness, forward order.
        set_config(3'd7, 1'b0, 5'd1);
        send_random(160);
        drain();

        // Full buffer in reverse; leave the frame open across the next write.
        set_config(3'd3, 1'b1, 5'd16);
        send_random(300);
        drain();

        // Count above the buffer depth saturates; finish the long frame.
        set_config(3'd5, 1'b0, 5'd31);
        send_random(300);
        drain();

        // Random settings, mostly short frames.
        while (items_sent < ITEM_TARGET) begin
            set_config($urandom_range(0, 7), $urandom_range(0, 1),
                       ($urandom_range(0, 99) < 85) ? $urandom_range(0, 4)
                                                    : $urandom_range(5, 31));
            send_random($urandom_range(60, 200));
            drain();
        end

        repeat (4) @(posedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule : testbench
